// File: hdl/remote_frame_receiver_defines.svh
// Assertion macros shared by the RTL.
`ifndef REMOTE_FRAME_RECEIVER_DEFINES_SVH
`define REMOTE_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define RFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define RFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/rfr_pkg.sv
package rfr_pkg;

	localparam int unsigned FrameLen = 6;
	localparam int unsigned FillW    = 3;

	localparam logic [7:0]  Sync0  = 8'hFF;
	localparam logic [7:0]  Sync1  = 8'h55;
	localparam logic [15:0] NoCode = 16'hFFFF;

	typedef logic [FillW-1:0] fill_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_NEW     = 2'd1,
		ST_BADCHK  = 2'd2,
		ST_DISCARD = 2'd3
	} status_t;

endpackage

// File: hdl/remote_frame_receiver.sv
// remote_frame_receiver
//
// Input channel: one received serial byte per transaction (rx_byte,
// in_valid/in_ready). Output channel: one result per input byte
// (held_code, status, out_valid/out_ready).
// Bytes build a six-byte window: 0xFF 0x55, low byte, ~low, high byte, ~high.
// A window without that header is dropped on its seventh byte (status 3).
// A good frame loads held_code unless the code is 0xFFFF; a complement
// mismatch reports status 2 and keeps the held code.
// The result is registered and is valid in the cycle after its input transaction.
// Throughput: one byte per cycle while results are drained; the window state
// is updated in the cycle a byte is taken, and the result sits in a single
// output register. in_ready is high whenever the output register is empty or
// being drained, so a stalled receiver stops input only while a result waits.
// Reset clears the fill count, the header flag, the stored code (to zero)
// and the output valid flag; the held_code output register is not reset.
`include "remote_frame_receiver_defines.svh"

module remote_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [15:0] held_code,
	output logic [1:0]  status,
	output logic        out_valid,
	input  logic        out_ready
);

	localparam int unsigned StoreDepth = rfr_pkg::FrameLen - 1;

	rfr_pkg::fill_t   fill_q, fill_d;
	logic             header_q, header_d;
	logic [7:0]       frame_q [StoreDepth];
	logic [15:0]      code_q, code_d;
	rfr_pkg::status_t status_d;
	rfr_pkg::status_t status_q;
	logic [15:0]      held_q;
	logic             valid_q;
	logic             accept;
	logic [15:0]      frame_code;
	logic             check_ok;

	assign in_ready = !valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign frame_code = {frame_q[4], frame_q[2]};
	assign check_ok   = (frame_q[2] == ~frame_q[3]) && (frame_q[4] == ~rx_byte);

	always_comb begin
		fill_d   = fill_q;
		header_d = header_q;
		code_d   = code_q;
		status_d = rfr_pkg::ST_NONE;
		if (fill_q >= rfr_pkg::fill_t'(rfr_pkg::FrameLen)) begin
			fill_d   = '0;
			header_d = 1'b0;
			status_d = rfr_pkg::ST_DISCARD;
		end else begin
			fill_d = fill_q + rfr_pkg::fill_t'(1);
			if (fill_q == rfr_pkg::fill_t'(1) && frame_q[0] == rfr_pkg::Sync0 &&
					rx_byte == rfr_pkg::Sync1) begin
				header_d = 1'b1;
			end
			if (header_d && fill_q == rfr_pkg::fill_t'(StoreDepth)) begin
				fill_d   = '0;
				header_d = 1'b0;
				if (check_ok) begin
					if (frame_code != rfr_pkg::NoCode) begin
						code_d   = frame_code;
						status_d = rfr_pkg::ST_NEW;
					end
				end else begin
					status_d = rfr_pkg::ST_BADCHK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			header_q <= 1'b0;
			code_q   <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				fill_q   <= fill_d;
				header_q <= header_d;
				code_q   <= code_d;
				valid_q  <= 1'b1;
			end else if (out_ready) begin
				valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q   <= code_d;
			status_q <= status_d;
			if (fill_q < rfr_pkg::fill_t'(StoreDepth)) begin
				frame_q[fill_q] <= rx_byte;
			end
		end
	end

	assign held_code = held_q;
	assign status    = status_q;
	assign out_valid = valid_q;

	`RFR_ASSERT_NOW(a_fill_range, clk, arst_n, 1'b1,
		fill_q <= rfr_pkg::fill_t'(rfr_pkg::FrameLen))

	`RFR_ASSERT_NOW(a_header_fill, clk, arst_n, header_q,
		fill_q >= rfr_pkg::fill_t'(2) && fill_q <= rfr_pkg::fill_t'(StoreDepth))

	`RFR_ASSERT_NOW(a_no_reserved_code, clk, arst_n, 1'b1, code_q != rfr_pkg::NoCode)

	`RFR_ASSERT_NEXT(a_discard, clk, arst_n,
		accept && fill_q == rfr_pkg::fill_t'(rfr_pkg::FrameLen),
		out_valid && status_q == rfr_pkg::ST_DISCARD && fill_q == rfr_pkg::fill_t'(0))

endmodule

// File: test/frame_code_checker.sv
module frame_code_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] held_code,
	input  logic [1:0]  status,
	input  logic        out_valid,
	input  logic        out_ready,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0]      code;
		rfr_pkg::status_t st;
	} frame_result_t;

	frame_result_t expected_results[$];

	rfr_pkg::fill_t win_fill;
	logic           win_header;
	logic [7:0]     win_bytes[rfr_pkg::FrameLen];
	logic [15:0]    code_now;

	function automatic frame_result_t absorb_byte(input logic [7:0] b);
		rfr_pkg::status_t st;
		logic [15:0]      code;
		st = rfr_pkg::ST_NONE;
		if (win_fill >= rfr_pkg::fill_t'(rfr_pkg::FrameLen)) begin
			win_fill   = '0;
			win_header = 1'b0;
			st         = rfr_pkg::ST_DISCARD;
		end else begin
			win_bytes[win_fill] = b;
			win_fill = win_fill + rfr_pkg::fill_t'(1);
			if (win_fill == rfr_pkg::fill_t'(2) && win_bytes[0] == rfr_pkg::Sync0 &&
					win_bytes[1] == rfr_pkg::Sync1)
				win_header = 1'b1;
			if (win_header && win_fill == rfr_pkg::fill_t'(rfr_pkg::FrameLen)) begin
				win_fill   = '0;
				win_header = 1'b0;
				if (win_bytes[2] == ~win_bytes[3] && win_bytes[4] == ~win_bytes[5]) begin
					code = {win_bytes[4], win_bytes[2]};
					if (code != rfr_pkg::NoCode) begin
						code_now = code;
						st       = rfr_pkg::ST_NEW;
					end
				end else begin
					st = rfr_pkg::ST_BADCHK;
				end
			end
		end
		return '{code: code_now, st: st};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t exp_res;
		if (!arst_n) begin
			win_fill   = '0;
			win_header = 1'b0;
			code_now   = '0;
			foreach (win_bytes[i])
				win_bytes[i] = '0;
			expected_results.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected transaction held_code=%h status=%0d",
						$time, held_code, status);
					errors++;
				end else begin
					exp_res = expected_results.pop_front();
					if (held_code !== exp_res.code) begin
						$display("%0t: held_code expected %h actual %h",
							$time, exp_res.code, held_code);
						errors++;
					end
					if (status !== exp_res.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_res.st, status);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(absorb_byte(rx_byte));
			pending = expected_results.size();
		end
	end

endmodule

// File: test/tb_remote_frame_receiver.sv
module tb_remote_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumItems = 1900;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        in_valid  = 1'b0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic [15:0] held_code;
	logic [1:0]  status;
	logic        out_valid;

	int errors;
	int pending;
	int sent        = 0;
	int tx_idle_pct = 19;
	int rx_idle_pct = 86;

	remote_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.held_code (held_code),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	frame_code_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.held_code (held_code),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		if (sent == NumItems / 3) begin
			tx_idle_pct = 86;
			rx_idle_pct = 19;
		end else if (sent == 2 * NumItems / 3) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	// header, lo, ~lo, hi, ~hi; an optional byte is xor-corrupted
	task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi,
			input int bad_pos, input logic [7:0] flip);
		logic [7:0] fr[6];
		fr = '{rfr_pkg::Sync0, rfr_pkg::Sync1, lo, ~lo, hi, ~hi};
		if (bad_pos >= 0)
			fr[bad_pos] = fr[bad_pos] ^ flip;
		foreach (fr[i])
			send_byte(fr[i]);
		if (bad_pos == 0 || bad_pos == 1)
			send_byte(8'($urandom));
	endtask

	initial begin
		logic [7:0] directed[25];
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] nb;
		int         kind;
		int         n;
		directed = '{
			8'hFF, 8'h55, 8'h00, 8'hFF, 8'h80, 8'h7F,
			8'hFF, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'h00,
			8'hFF, 8'h55, 8'h12, 8'hEE, 8'h34, 8'hCB,
			8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h55, 8'h00
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i]);

		while (sent < NumItems) begin
			kind = $urandom_range(99);
			if (kind < 65) begin
				if ($urandom_range(19) == 0) begin
					lo = 8'hFF;
					hi = 8'hFF;
				end else begin
					lo = 8'($urandom);
					hi = 8'($urandom);
				end
				send_frame(lo, hi, -1, 8'h00);
			end else if (kind < 82) begin
				send_frame(8'($urandom), 8'($urandom), $urandom_range(5),
					8'($urandom_range(255, 1)));
			end else begin
				n = $urandom_range(9, 1);
				repeat (n) begin
					case ($urandom_range(3))
						0: nb = rfr_pkg::Sync0;
						1: nb = rfr_pkg::Sync1;
						default: nb = 8'($urandom);
					endcase
					send_byte(nb);
				end
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
